// ----- rtl/zdil_pkg.sv -----
// ----------------------------------------------------------------------------
// zdil_pkg
// shared types, request codes and config indexes of the zone date interval lookup
// ----------------------------------------------------------------------------
package zdil_pkg;

    localparam logic [1:0] REQ_HDR = 2'd0;
    localparam logic [1:0] REQ_ENT = 2'd1;
    localparam logic [1:0] REQ_QRY = 2'd2;

    localparam logic CFG_ZONE_COUNT = 1'b0;
    localparam logic CFG_NONE_CODE  = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  zone_slot;
        logic [15:0] zone_id;
        logic [6:0]  entry_count;
        logic [5:0]  entry_index;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [7:0]  code;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [15:0] result_code;
    } out_t;

    typedef struct packed {
        logic [6:0]  zone_count;
        logic [15:0] none_code;
    } cfg_t;

    typedef struct packed {
        logic [15:0] zone_id;
        logic [6:0]  entry_count;
    } zone_rec_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [7:0] code;
    } date_ent_t;

endpackage

// ----- rtl/zdil_ram.sv -----
// ----------------------------------------------------------------------------
// zdil_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module zdil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/zdil_seq.sv -----
// ----------------------------------------------------------------------------
// zdil_seq
// table writes and the query walk over the zone and entry memories
// ----------------------------------------------------------------------------
module zdil_seq #(
    parameter int MAX_ZONES   = 64,
    parameter int MAX_ENTRIES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  zdil_pkg::in_t   in_data,
    input  zdil_pkg::cfg_t  cfg,
    output logic            res_valid,
    input  logic            res_ready,
    output zdil_pkg::out_t  res
);

    localparam int ZA  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int EA  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ZCW = $clog2(MAX_ZONES + 1);
    localparam int ECW = $clog2(MAX_ENTRIES + 1);
    localparam int ZW  = $bits(zdil_pkg::zone_rec_t);
    localparam int EW  = $bits(zdil_pkg::date_ent_t);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ZSCAN  = 3'd1;
    localparam logic [2:0] S_ESCAN  = 3'd2;
    localparam logic [2:0] S_EFINAL = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [ZA-1:0]  cur_reg, cur_next;
    logic [ZA-1:0]  slot_reg, slot_next;
    logic [EA-1:0]  ei_reg, ei_next;
    logic [ZCW-1:0] lim_reg, lim_next;
    logic [ECW-1:0] n_reg, n_next;
    logic [15:0]    qid_reg, qid_next;
    logic [8:0]     qdate_reg, qdate_next;
    zdil_pkg::out_t pend_reg, pend_next;

    logic           accept;
    logic           z_we, e_we;
    logic [ZA-1:0]  z_raddr;
    logic [ZA-1:0]  e_rslot;
    logic [EA-1:0]  e_ridx;
    logic [ZW-1:0]  z_rdata;
    logic [EW-1:0]  e_rdata;
    zdil_pkg::zone_rec_t z_q;
    zdil_pkg::date_ent_t e_q;
    zdil_pkg::zone_rec_t z_wrec;
    zdil_pkg::date_ent_t e_wrec;
    logic [ZCW-1:0] lim_in;
    logic [ECW-1:0] n_hit;
    logic [8:0]     e_date;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = pend_reg;

    assign z_q    = zdil_pkg::zone_rec_t'(z_rdata);
    assign e_q    = zdil_pkg::date_ent_t'(e_rdata);
    assign e_date = {e_q.month, e_q.day};

    assign z_wrec = '{zone_id: in_data.zone_id, entry_count: in_data.entry_count};
    assign e_wrec = '{month: in_data.month, day: in_data.day, code: in_data.code};

    // out-of-range slots and indexes leave the tables alone
    assign z_we = accept && (in_data.req_type == zdil_pkg::REQ_HDR)
                  && (32'(in_data.zone_slot) < MAX_ZONES);
    assign e_we = accept && (in_data.req_type == zdil_pkg::REQ_ENT)
                  && (32'(in_data.zone_slot) < MAX_ZONES)
                  && (32'(in_data.entry_index) < MAX_ENTRIES);

    assign lim_in = (32'(cfg.zone_count) > MAX_ZONES) ? ZCW'(MAX_ZONES)
                                                      : ZCW'(cfg.zone_count);
    assign n_hit  = (32'(z_q.entry_count) > MAX_ENTRIES) ? ECW'(MAX_ENTRIES)
                                                         : ECW'(z_q.entry_count);

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        slot_next  = slot_reg;
        ei_next    = ei_reg;
        lim_next   = lim_reg;
        n_next     = n_reg;
        qid_next   = qid_reg;
        qdate_next = qdate_reg;
        pend_next  = pend_reg;
        z_raddr    = '0;
        e_rslot    = slot_reg;
        e_ridx     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_data.req_type == zdil_pkg::REQ_QRY))
                begin
                    qid_next   = in_data.zone_id;
                    qdate_next = {in_data.month, in_data.day};
                    lim_next   = lim_in;
                    cur_next   = '0;
                    if (lim_in == '0)
                    begin
                        pend_next  = '{found: 1'b0, result_code: cfg.none_code};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_ZSCAN;
                    end
                end
            end
            S_ZSCAN:
            begin
                // rdata holds the record of slot cur_reg, next slot is read ahead
                z_raddr = ZA'(32'(cur_reg) + 1);
                e_rslot = cur_reg;
                if (z_q.zone_id == qid_reg)
                begin
                    slot_next = cur_reg;
                    n_next    = n_hit;
                    if (n_hit == '0)
                    begin
                        pend_next  = '{found: 1'b0, result_code: cfg.none_code};
                        state_next = S_EMIT;
                    end
                    else if (32'(n_hit) == 1)
                    begin
                        e_ridx     = '0;
                        state_next = S_EFINAL;
                    end
                    else
                    begin
                        e_ridx     = EA'(1);
                        ei_next    = EA'(1);
                        state_next = S_ESCAN;
                    end
                end
                else if ((32'(cur_reg) + 1) == 32'(lim_reg))
                begin
                    pend_next  = '{found: 1'b0, result_code: cfg.none_code};
                    state_next = S_EMIT;
                end
                else
                begin
                    cur_next = ZA'(32'(cur_reg) + 1);
                end
            end
            S_ESCAN:
            begin
                if (e_date == qdate_reg)
                begin
                    pend_next  = '{found: 1'b1, result_code: {8'h00, e_q.code}};
                    state_next = S_EMIT;
                end
                else if (qdate_reg < e_date)
                begin
                    e_ridx     = EA'(32'(ei_reg) - 1);
                    state_next = S_EFINAL;
                end
                else if ((32'(ei_reg) + 1) == 32'(n_reg))
                begin
                    // year wrap back to the first entry
                    e_ridx     = '0;
                    state_next = S_EFINAL;
                end
                else
                begin
                    e_ridx  = EA'(32'(ei_reg) + 1);
                    ei_next = EA'(32'(ei_reg) + 1);
                end
            end
            S_EFINAL:
            begin
                pend_next  = '{found: 1'b1, result_code: {8'h00, e_q.code}};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        slot_reg  <= slot_next;
        ei_reg    <= ei_next;
        lim_reg   <= lim_next;
        n_reg     <= n_next;
        qid_reg   <= qid_next;
        qdate_reg <= qdate_next;
        pend_reg  <= pend_next;
    end

    zdil_ram #(
        .WIDTH (ZW),
        .DEPTH (2 ** ZA),
        .AW    (ZA)
    ) u_zone_ram (
        .clk   (clk),
        .we    (z_we),
        .waddr (ZA'(in_data.zone_slot)),
        .wdata (ZW'(z_wrec)),
        .raddr (z_raddr),
        .rdata (z_rdata)
    );

    zdil_ram #(
        .WIDTH (EW),
        .DEPTH ((2 ** ZA) * (2 ** EA)),
        .AW    (ZA + EA)
    ) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr ({ZA'(in_data.zone_slot), EA'(in_data.entry_index)}),
        .wdata (EW'(e_wrec)),
        .raddr ({e_rslot, e_ridx}),
        .rdata (e_rdata)
    );

endmodule

// ----- rtl/zone_date_interval_lookup.sv -----
// ----------------------------------------------------------------------------
// zone_date_interval_lookup
// per-zone date table loader and floor lookup of the entry for a date
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_data  (zdil_pkg::in_t)
//  out     | output    | out_valid / out_ready  | out_data (zdil_pkg::out_t)
//  cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
//  header and entry writes keep the block idle; in_ready stays high after them
//  a query reads s zone slots, then e entries of the matching zone, one read a
//  cycle from the zone and entry memories
//  the result waits in an output register; a new request is taken while it waits
//  reset clears control and config registers; table memories are not cleared
// ----------------------------------------------------------------------------
module zone_date_interval_lookup #(
    parameter int MAX_ZONES   = 64,
    parameter int MAX_ENTRIES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  zdil_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output zdil_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [15:0]     cfg_data
);

    zdil_pkg::cfg_t cfg_reg;
    logic           out_valid_reg;
    zdil_pkg::out_t out_data_reg;
    logic           res_valid;
    logic           res_ready;
    zdil_pkg::out_t res;

    assign res_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                zdil_pkg::CFG_ZONE_COUNT: cfg_reg.zone_count <= cfg_data[6:0];
                zdil_pkg::CFG_NONE_CODE:  cfg_reg.none_code  <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    zdil_seq #(
        .MAX_ZONES   (MAX_ZONES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ----- rtl/zdil_check.sv -----
// ----------------------------------------------------------------------------
// zdil_check
// port-level checks of the zone date interval lookup, bound to the top level
// ----------------------------------------------------------------------------
module zdil_check (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input zdil_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input zdil_pkg::out_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // table writes never make the block busy
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type != zdil_pkg::REQ_QRY) |=> in_ready)
        else $error("ready dropped after a table write");

    // a query request drops in_ready in the cycle after it is taken
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.req_type == zdil_pkg::REQ_QRY) |=> !in_ready)
        else $error("ready high right after a query request");

    // a new result only comes out of a running query
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a query in progress");

    // a found entry code is eight bits wide
    a_code_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.result_code[15:8] == 8'h00)
        else $error("found result has upper code bits set");

endmodule

bind zone_date_interval_lookup zdil_check u_zdil_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
